// ===== design/sold_pkg.sv =====
// ----------------------------------------------------------------------------
// sold_pkg
// Shared constants and types for the sync/opcode/length packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package sold_pkg;

   // Payload buffer geometry
   localparam int BufferDepth = 64;
   localparam int AddrW       = $clog2(BufferDepth);
   localparam int CntW        = AddrW + 1;
   localparam int MaxPayload  = BufferDepth - 2;

   // Field widths
   localparam int ByteW = 8;
   localparam int LenW  = 6;

   // Sync byte after reset
   localparam logic [ByteW-1:0] ResetSync = 8'hAA;

   // Access to the payload buffer, driven by the frame controller
   typedef struct packed {
      logic             wr_en;
      logic [AddrW-1:0] wr_addr;
      logic [ByteW-1:0] wr_data;
      logic [AddrW-1:0] rd_addr;
   } ram_req_type;

endpackage

`default_nettype wire

// ===== design/sold_ram.sv =====
// ----------------------------------------------------------------------------
// sold_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sold_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write on enable, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/sold_ctrl.sv =====
// ----------------------------------------------------------------------------
// sold_ctrl
// Frame controller: hunts for sync, captures opcode and length, writes the
// payload into the buffer, then reads it back one beat per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sold_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // configuration
   input  wire logic                         csr_wr_en,
   input  wire logic [sold_pkg::ByteW-1:0]   csr_wr_data,
   // received bytes
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [sold_pkg::ByteW-1:0]   req_rx_byte,
   // packet beats
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [sold_pkg::ByteW-1:0]   rsp_packet_opcode,
   output logic      [sold_pkg::LenW-1:0]    rsp_packet_length,
   output logic      [sold_pkg::ByteW-1:0]   rsp_payload_byte,
   output logic                              rsp_last_of_packet,
   // payload buffer
   output sold_pkg::ram_req_type             ram_req,
   input  wire logic [sold_pkg::ByteW-1:0]   ram_rdata
);

   localparam logic [2:0] StHunt    = 3'd0;
   localparam logic [2:0] StOpcode  = 3'd1;
   localparam logic [2:0] StLength  = 3'd2;
   localparam logic [2:0] StPayload = 3'd3;
   localparam logic [2:0] StFetch   = 3'd4;
   localparam logic [2:0] StShow    = 3'd5;

   logic [2:0]                      state_ff, state_in;
   logic [sold_pkg::ByteW-1:0]      sync_ff, sync_in;
   logic [sold_pkg::ByteW-1:0]      opcode_ff, opcode_in;
   logic [sold_pkg::ByteW-1:0]      length_ff, length_in;
   logic [sold_pkg::CntW-1:0]       cnt_ff, cnt_in;
   logic [sold_pkg::AddrW-1:0]      idx_ff, idx_in;
   logic                            valid_ff, valid_in;
   logic                            empty_ff, empty_in;

   logic                            req_take;
   logic                            rsp_take;
   logic [sold_pkg::CntW-1:0]       cnt_next;
   logic [sold_pkg::CntW-1:0]       idx_next;
   logic                            len_match;
   logic                            show_last;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = valid_ff && !rsp_stall;
   assign cnt_next = cnt_ff + 1'b1;
   assign idx_next = {1'b0, idx_ff} + 1'b1;
   assign len_match = (16'(length_ff) == 16'(cnt_next));
   assign show_last = empty_ff || (16'(length_ff) == 16'(idx_next));

   // Hold off input while a packet is being read out
   assign req_stall = (state_ff == StFetch) || (state_ff == StShow);

   // Next state and datapath
   always_comb begin
      state_in  = state_ff;
      opcode_in = opcode_ff;
      length_in = length_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      valid_in  = valid_ff;
      empty_in  = empty_ff;
      sync_in   = csr_wr_en ? csr_wr_data : sync_ff;

      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = cnt_ff[sold_pkg::AddrW-1:0];
      ram_req.wr_data = req_rx_byte;
      ram_req.rd_addr = '0;

      unique case (state_ff)
         StHunt: begin
            if (req_take && (req_rx_byte == sync_ff)) begin
               state_in = StOpcode;
            end
         end
         StOpcode: begin
            if (req_take) begin
               opcode_in = req_rx_byte;
               state_in  = StLength;
            end
         end
         StLength: begin
            if (req_take) begin
               length_in = req_rx_byte;
               cnt_in    = '0;
               idx_in    = '0;
               // Empty packet: one beat straight away
               if (req_rx_byte == '0) begin
                  state_in = StShow;
                  valid_in = 1'b1;
                  empty_in = 1'b1;
               end else begin
                  state_in = StPayload;
               end
            end
         end
         StPayload: begin
            if (req_take) begin
               ram_req.wr_en = 1'b1;
               cnt_in        = cnt_next;
               if (len_match) begin
                  state_in = StFetch;
               end else if (cnt_next == sold_pkg::CntW'(sold_pkg::MaxPayload)) begin
                  // Oversized packet: drop it
                  state_in = StHunt;
               end
            end
         end
         StFetch: begin
            // Prime the read of the first payload byte
            ram_req.rd_addr = '0;
            idx_in          = '0;
            valid_in        = 1'b1;
            empty_in        = 1'b0;
            state_in        = StShow;
         end
         StShow: begin
            // Advance the read address on a taken beat, else re-read the same entry
            if (rsp_take) begin
               ram_req.rd_addr = idx_next[sold_pkg::AddrW-1:0];
               idx_in          = idx_next[sold_pkg::AddrW-1:0];
               if (show_last) begin
                  valid_in = 1'b0;
                  empty_in = 1'b0;
                  state_in = StHunt;
               end
            end else begin
               ram_req.rd_addr = idx_ff;
            end
         end
         default: begin
            state_in = StHunt;
            valid_in = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= StHunt;
         sync_ff   <= sold_pkg::ResetSync;
         valid_ff  <= 1'b0;
         empty_ff  <= 1'b0;
         opcode_ff <= '0;
         length_ff <= '0;
         cnt_ff    <= '0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         sync_ff   <= sync_in;
         valid_ff  <= valid_in;
         empty_ff  <= empty_in;
         opcode_ff <= opcode_in;
         length_ff <= length_in;
         cnt_ff    <= cnt_in;
         idx_ff    <= idx_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_packet_opcode  = opcode_ff;
   assign rsp_packet_length  = length_ff[sold_pkg::LenW-1:0];
   assign rsp_payload_byte   = empty_ff ? '0 : ram_rdata;
   assign rsp_last_of_packet = show_last;

endmodule

`default_nettype wire

// ===== design/sync_opcode_length_deframer_top.sv =====
// The fetch state follows the last payload byte; the show state then presents
// the first beat (for an empty packet, in the cycle after the length byte).
// Throughput: one received byte per cycle while framing; read-out gives one
// beat per cycle while not stalled from the payload buffer's registered read
// port, up to 62. Input is held off during read-out. Synchronous active-high
// reset returns to hunting with sync byte 0xAA but does not clear the buffer.
// ----------------------------------------------------------------------------
// sync_opcode_length_deframer_top
// Byte-stream deframer: sync, opcode, length, payload, emitted as beats.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_opcode_length_deframer_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [sold_pkg::ByteW-1:0]  csr_wr_data,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [sold_pkg::ByteW-1:0]  req_rx_byte,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic      [sold_pkg::ByteW-1:0]  rsp_packet_opcode,
   output logic      [sold_pkg::LenW-1:0]   rsp_packet_length,
   output logic      [sold_pkg::ByteW-1:0]  rsp_payload_byte,
   output logic                             rsp_last_of_packet
);

   sold_pkg::ram_req_type            ram_req;
   logic [sold_pkg::ByteW-1:0]       ram_rdata;

   // Frame controller
   sold_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_packet_opcode  (rsp_packet_opcode),
      .rsp_packet_length  (rsp_packet_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_last_of_packet (rsp_last_of_packet),
      .ram_req            (ram_req),
      .ram_rdata          (ram_rdata)
   );

   // Payload buffer
   sold_ram #(
      .Width (sold_pkg::ByteW),
      .Depth (sold_pkg::BufferDepth)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rdata)
   );

endmodule

`default_nettype wire
